// File: rtl/core/dsd_pkg.sv
// Shared types and constants for the dominant stride detector.
// Used by dsd_ctrl, dsd_datapath and dominant_stride_detector_unit; no dependencies.
`timescale 1ns / 1ps

package dsd_pkg;

    // Bucket table size and derived widths
    localparam int BUCKETS   = 16;
    localparam int IDX_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int USED_W    = $clog2(BUCKETS + 1);

    // Field widths
    localparam int ADDR_W    = 64;
    localparam int GAP_W     = 16;
    localparam int VOTE_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTES = 1'b1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] MAX_GAP_RST   = 16'h2000;
    localparam logic [CFG_W-1:0] MIN_VOTES_RST = 16'd4;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_VOTE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;       // latch input word, form gap
        logic vote;       // apply gap to bucket table
        logic scan_init;  // reset scan pointer and running best
        logic scan_step;  // examine one bucket
        logic emit;       // load result register, clear stream state
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;       // latched word closes the stream
        logic scan_done;  // scan pointer at final bucket
        logic out_full;   // result register holds a word not taken this cycle
    } status_t;

endpackage

// File: rtl/core/dsd_ctrl.sv
// Sequencing controller for the dominant stride detector.
// Depends on dsd_pkg for state, command and status types.
`timescale 1ns / 1ps

module dsd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  dsd_pkg::status_t status,
    output dsd_pkg::cmd_t    cmd
);

    dsd_pkg::state_t state_reg;
    dsd_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            dsd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = dsd_pkg::ST_VOTE;
                end
            end
            dsd_pkg::ST_VOTE:
            begin
                cmd.vote = 1'b1;
                if (status.last)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = dsd_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = dsd_pkg::ST_IDLE;
                end
            end
            dsd_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = dsd_pkg::ST_EMIT;
                end
            end
            dsd_pkg::ST_EMIT:
            begin
                // hold until the result register can take the word
                if (!status.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = dsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dsd_pkg::ST_IDLE;
            end
        endcase
    end

    // A word is taken only from idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> state_reg == dsd_pkg::ST_IDLE)
        else $error("word taken outside idle");

    // Voting always leaves the vote state in the cycle after it
    a_vote_one: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dsd_pkg::ST_VOTE |=>
            state_reg == dsd_pkg::ST_IDLE || state_reg == dsd_pkg::ST_SCAN)
        else $error("vote state held");

    // Emit never overwrites a waiting result
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !status.out_full)
        else $error("result overwritten");

endmodule

// File: rtl/core/dsd_datapath.sv
// Datapath of the dominant stride detector: gap former, bucket table, winner scan,
// configuration registers and result register. Depends on dsd_pkg.
`timescale 1ns / 1ps

module dsd_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  dsd_pkg::cmd_t                  cmd,
    output dsd_pkg::status_t               status,
    input  logic [dsd_pkg::ADDR_W-1:0]     address,
    input  logic                           last,
    input  logic                           cfg_we,
    input  logic [dsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsd_pkg::CFG_W-1:0]      cfg_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [dsd_pkg::GAP_W-1:0]      stride
);

    // Configuration
    logic [dsd_pkg::CFG_W-1:0]  max_gap_reg;
    logic [dsd_pkg::CFG_W-1:0]  min_votes_reg;

    // Stream state
    logic [dsd_pkg::ADDR_W-1:0] prev_address_reg;
    logic                       awaiting_reg;
    logic                       last_reg;
    logic                       gap_ok_reg;
    logic [dsd_pkg::GAP_W-1:0]  gap_reg;
    logic [dsd_pkg::USED_W-1:0] used_reg;
    logic [dsd_pkg::USED_W-1:0] used_next;

    // Bucket table, valid below used_reg
    logic [dsd_pkg::GAP_W-1:0]  bucket_gap_reg   [dsd_pkg::BUCKETS];
    logic [dsd_pkg::VOTE_W-1:0] bucket_votes_reg [dsd_pkg::BUCKETS];

    // Scan
    logic [dsd_pkg::IDX_W-1:0]  scan_idx_reg;
    logic [dsd_pkg::VOTE_W-1:0] best_votes_reg;
    logic [dsd_pkg::GAP_W-1:0]  best_gap_reg;

    // Result
    logic                       out_valid_reg;
    logic [dsd_pkg::GAP_W-1:0]  stride_reg;

    logic [dsd_pkg::ADDR_W-1:0] gap_full;
    logic                       gap_ok;
    logic [dsd_pkg::BUCKETS-1:0] hit;
    logic                       any_hit;
    logic                       alloc;
    logic [dsd_pkg::VOTE_W-1:0] scan_votes;
    logic                       scan_live;

    // Form the gap and decide whether it votes
    assign gap_full = address - prev_address_reg;
    assign gap_ok   = !awaiting_reg && (prev_address_reg != '0) && (address != '0)
                      && (gap_full != '0)
                      && (gap_full[dsd_pkg::ADDR_W-1:dsd_pkg::GAP_W] == '0)
                      && (gap_full[dsd_pkg::GAP_W-1:0] <= max_gap_reg);

    // Match the gap against live buckets
    always_comb
    begin
        for (int i = 0; i < dsd_pkg::BUCKETS; i++)
        begin
            hit[i] = (dsd_pkg::USED_W'(i) < used_reg) && (bucket_gap_reg[i] == gap_reg);
        end
    end

    assign any_hit = |hit;
    assign alloc   = cmd.vote && gap_ok_reg && !any_hit
                     && (used_reg < dsd_pkg::USED_W'(dsd_pkg::BUCKETS));

    // Fill count
    always_comb
    begin
        used_next = used_reg;
        if (cmd.emit)
        begin
            used_next = '0;
        end
        else if (alloc)
        begin
            used_next = used_reg + 1'b1;
        end
    end

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg   <= dsd_pkg::MAX_GAP_RST;
            min_votes_reg <= dsd_pkg::MIN_VOTES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dsd_pkg::CFG_MAX_GAP:   max_gap_reg   <= cfg_data;
                dsd_pkg::CFG_MIN_VOTES: min_votes_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Stream control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_address_reg <= '0;
            awaiting_reg     <= 1'b1;
            last_reg         <= 1'b0;
            gap_ok_reg       <= 1'b0;
            used_reg         <= '0;
        end
        else
        begin
            used_reg <= used_next;
            if (cmd.take)
            begin
                prev_address_reg <= address;
                awaiting_reg     <= 1'b0;
                last_reg         <= last;
                gap_ok_reg       <= gap_ok;
            end
            else if (cmd.emit)
            begin
                prev_address_reg <= '0;
                awaiting_reg     <= 1'b1;
                last_reg         <= 1'b0;
                gap_ok_reg       <= 1'b0;
            end
        end
    end

    // Gap payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            gap_reg <= gap_full[dsd_pkg::GAP_W-1:0];
        end
    end

    // Vote into a matching bucket or open a new one; counts saturate
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < dsd_pkg::BUCKETS; i++)
        begin
            if (cmd.vote && gap_ok_reg && hit[i])
            begin
                if (bucket_votes_reg[i] != '1)
                begin
                    bucket_votes_reg[i] <= bucket_votes_reg[i] + 1'b1;
                end
            end
            else if (alloc && (used_reg == dsd_pkg::USED_W'(i)))
            begin
                bucket_gap_reg[i]   <= gap_reg;
                bucket_votes_reg[i] <= dsd_pkg::VOTE_W'(1);
            end
        end
    end

    // Winner scan: one bucket per cycle, strict greater keeps the earliest
    assign scan_votes = bucket_votes_reg[scan_idx_reg];
    assign scan_live  = dsd_pkg::USED_W'(scan_idx_reg) < used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            best_votes_reg <= '0;
            best_gap_reg   <= '0;
        end
        else if (cmd.scan_step && scan_live && (scan_votes > best_votes_reg))
        begin
            best_votes_reg <= scan_votes;
            best_gap_reg   <= bucket_gap_reg[scan_idx_reg];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            stride_reg <= (best_votes_reg >= dsd_pkg::VOTE_W'(min_votes_reg))
                          ? best_gap_reg : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign stride           = stride_reg;
    assign status.last      = last_reg;
    assign status.scan_done = scan_idx_reg == dsd_pkg::IDX_W'(dsd_pkg::BUCKETS - 1);
    assign status.out_full  = out_valid_reg && out_stall;

    // Fill count stays within the table
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= dsd_pkg::USED_W'(dsd_pkg::BUCKETS))
        else $error("bucket count overflow");

    // Emit leaves the stream cleared
    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> used_reg == '0 && awaiting_reg && out_valid_reg)
        else $error("stream state not cleared on emit");

    // At most one bucket matches a gap
    a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.vote |-> $onehot0(hit))
        else $error("duplicate bucket gap");

endmodule

// File: rtl/core/dominant_stride_detector_unit.sv
// Dominant stride detector: finds the most frequent gap between consecutive record addresses.
// Each address word passes two steps: one takes it and forms the gap, one votes it into
// the flop-based bucket table (all buckets compared at once). A word with last set adds a
// winner scan through the table, one bucket a cycle, and an emit step that waits while
// the result register still holds an untaken word. Input stall
// is low only when idle; a finished result waits in its own register and does not block
// new input. Configuration: index 0 max_gap, index 1 min_votes; write only while idle.
// Depends on dsd_pkg, dsd_ctrl and dsd_datapath.
`timescale 1ns / 1ps

module dominant_stride_detector_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dsd_pkg::ADDR_W-1:0]     address,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [dsd_pkg::GAP_W-1:0]      stride,
    input  logic                           cfg_we,
    input  logic [dsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsd_pkg::CFG_W-1:0]      cfg_data
);

    dsd_pkg::cmd_t    cmd;
    dsd_pkg::status_t status;

    // Sequencer
    dsd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Gap, bucket table and result
    dsd_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .address   (address),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stride    (stride)
    );

endmodule
